// File: design/rwhp_pkg.sv
package rwhp_pkg;

    // chunk tags as they read little endian from the shift register
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // format codes
    localparam logic [15:0] FMT_PCM = 16'h0001;
    localparam logic [15:0] FMT_EXT = 16'hFFFE;

    // fmt body sizes and header length
    localparam logic [31:0] FMT_BASE_LEN = 32'd16;
    localparam logic [31:0] FMT_EXT_LEN  = 32'd40;
    localparam logic [32:0] HEAD_LEN     = 33'd12;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_RIFF_TAG    = 4'd2,
        ST_WAVE_TAG    = 4'd3,
        ST_FMT_SHORT   = 4'd4,
        ST_FORMAT      = 4'd5,
        ST_EXT_SHORT   = 4'd6,
        ST_EXT_SUBFMT  = 4'd7,
        ST_NO_FMT      = 4'd8,
        ST_CHANNELS    = 4'd9,
        ST_BITS        = 4'd10,
        ST_RATE_ZERO   = 4'd11,
        ST_NO_DATA     = 4'd12
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  channel_count;
        logic        sample_format;
        logic [31:0] sample_rate;
        logic [32:0] data_offset;
        logic [31:0] data_length;
    } result_t;

endpackage

// File: design/rwhp_walker.sv
module rwhp_walker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      in_byte,
    input  logic            is_last,
    output rwhp_pkg::result_t result
);

    typedef enum logic [1:0] {
        PH_OUTER,
        PH_HEADER,
        PH_BODY,
        PH_PAD
    } phase_t;

    logic [32:0]       pos_reg,      pos_next;
    logic [32:0]       limit_reg,    limit_next;
    phase_t            phase_reg,    phase_next;
    logic [31:0]       shift_reg,    shift_next;
    logic [31:0]       tag_reg,      tag_next;
    logic [31:0]       length_reg,   length_next;
    logic [31:0]       count_reg,    count_next;
    logic [15:0]       fmt_reg,      fmt_next;
    logic [15:0]       sub_reg,      sub_next;
    logic [15:0]       chan_reg,     chan_next;
    logic [15:0]       bits_reg,     bits_next;
    logic [31:0]       rate_reg,     rate_next;
    logic              found_reg,    found_next;
    logic [32:0]       start_reg,    start_next;
    logic [31:0]       span_reg,     span_next;
    rwhp_pkg::status_t err_reg,      err_next;

    logic [31:0]       shifted;
    logic [31:0]       count_inc;
    rwhp_pkg::status_t err_final;
    rwhp_pkg::status_t st;
    logic              frame2;
    logic              frame4;

    assign shifted   = {in_byte, shift_reg[31:8]};
    assign count_inc = count_reg + 32'd1;

    // per-word state update
    always_comb
    begin
        pos_next    = pos_reg;
        limit_next  = limit_reg;
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        tag_next    = tag_reg;
        length_next = length_reg;
        count_next  = count_reg;
        fmt_next    = fmt_reg;
        sub_next    = sub_reg;
        chan_next   = chan_reg;
        bits_next   = bits_reg;
        rate_next   = rate_reg;
        found_next  = found_reg;
        start_next  = start_reg;
        span_next   = span_reg;
        err_next    = err_reg;

        if (err_reg == rwhp_pkg::ST_OK)
        begin
            if (phase_reg == PH_OUTER)
            begin
                if (pos_reg < rwhp_pkg::HEAD_LEN)
                begin
                    shift_next = shifted;
                    if (pos_reg == 33'd3 && shifted != rwhp_pkg::TAG_RIFF)
                        err_next = rwhp_pkg::ST_RIFF_TAG;
                    if (pos_reg == 33'd7)
                        limit_next = {1'b0, shifted} + 33'd8;
                    if (pos_reg == 33'd11)
                    begin
                        if (shifted != rwhp_pkg::TAG_WAVE)
                            err_next = rwhp_pkg::ST_WAVE_TAG;
                        phase_next = PH_HEADER;
                        count_next = '0;
                    end
                end
            end
            else if (pos_reg >= rwhp_pkg::HEAD_LEN && pos_reg < limit_reg)
            begin
                case (phase_reg)
                    // chunk tag and length
                    PH_HEADER:
                    begin
                        shift_next = shifted;
                        count_next = count_inc;
                        if (count_inc == 32'd4)
                            tag_next = shifted;
                        if (count_inc == 32'd8)
                        begin
                            length_next = shifted;
                            count_next  = '0;
                            phase_next  = PH_BODY;
                            if (tag_reg == rwhp_pkg::TAG_FMT && shifted < rwhp_pkg::FMT_BASE_LEN)
                            begin
                                err_next = rwhp_pkg::ST_FMT_SHORT;
                            end
                            else
                            begin
                                if (tag_reg == rwhp_pkg::TAG_DATA)
                                begin
                                    start_next = pos_reg + 33'd1;
                                    span_next  = '0;
                                end
                                if (shifted == 32'd0)
                                    phase_next = PH_HEADER;
                            end
                        end
                    end
                    // chunk body: fmt field capture or data span count
                    PH_BODY:
                    begin
                        count_next = count_inc;
                        if (tag_reg == rwhp_pkg::TAG_FMT)
                        begin
                            case (count_reg)
                                32'd0:  fmt_next  = {8'd0, in_byte};
                                32'd1:  fmt_next  = {in_byte, fmt_reg[7:0]};
                                32'd2:  chan_next = {8'd0, in_byte};
                                32'd3:  chan_next = {in_byte, chan_reg[7:0]};
                                32'd4:  rate_next = {24'd0, in_byte};
                                32'd5:  rate_next = {16'd0, in_byte, rate_reg[7:0]};
                                32'd6:  rate_next = {8'd0, in_byte, rate_reg[15:0]};
                                32'd7:  rate_next = {in_byte, rate_reg[23:0]};
                                32'd14: bits_next = {8'd0, in_byte};
                                32'd15: bits_next = {in_byte, bits_reg[7:0]};
                                32'd24: sub_next  = {8'd0, in_byte};
                                32'd25: sub_next  = {in_byte, sub_reg[7:0]};
                                default: ;
                            endcase
                            if (count_inc == rwhp_pkg::FMT_BASE_LEN)
                            begin
                                if (fmt_reg == rwhp_pkg::FMT_PCM)
                                    found_next = 1'b1;
                                else if (fmt_reg != rwhp_pkg::FMT_EXT)
                                    err_next = rwhp_pkg::ST_FORMAT;
                                else if (length_reg < rwhp_pkg::FMT_EXT_LEN)
                                    err_next = rwhp_pkg::ST_EXT_SHORT;
                            end
                            if (count_inc == rwhp_pkg::FMT_EXT_LEN
                                && fmt_reg == rwhp_pkg::FMT_EXT)
                            begin
                                if (sub_reg != rwhp_pkg::FMT_PCM)
                                    err_next = rwhp_pkg::ST_EXT_SUBFMT;
                                else
                                    found_next = 1'b1;
                            end
                        end
                        else if (tag_reg == rwhp_pkg::TAG_DATA)
                        begin
                            span_next = count_inc;
                        end
                        if (count_inc == length_reg)
                        begin
                            phase_next = length_reg[0] ? PH_PAD : PH_HEADER;
                            count_next = '0;
                        end
                    end
                    // pad word after an odd body
                    PH_PAD:
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                    end
                    default: ;
                endcase
            end
        end

        if (pos_reg != {33{1'b1}})
            pos_next = pos_reg + 33'd1;
    end

    // result from the state after this word
    always_comb
    begin
        err_final = err_next;
        if (err_next == rwhp_pkg::ST_OK && phase_next == PH_BODY
            && tag_next == rwhp_pkg::TAG_FMT)
        begin
            if (count_next < rwhp_pkg::FMT_BASE_LEN)
                err_final = rwhp_pkg::ST_FMT_SHORT;
            else if (fmt_next == rwhp_pkg::FMT_EXT && count_next < rwhp_pkg::FMT_EXT_LEN)
                err_final = rwhp_pkg::ST_EXT_SHORT;
        end

        if (pos_next < rwhp_pkg::HEAD_LEN)
            st = rwhp_pkg::ST_SHORT;
        else if (err_final != rwhp_pkg::ST_OK)
            st = err_final;
        else if (!found_next)
            st = rwhp_pkg::ST_NO_FMT;
        else if (chan_next != 16'd1 && chan_next != 16'd2)
            st = rwhp_pkg::ST_CHANNELS;
        else if (bits_next != 16'd8 && bits_next != 16'd16)
            st = rwhp_pkg::ST_BITS;
        else if (rate_next == 32'd0)
            st = rwhp_pkg::ST_RATE_ZERO;
        else if (span_next == 32'd0)
            st = rwhp_pkg::ST_NO_DATA;
        else
            st = rwhp_pkg::ST_OK;

        // frame of 2 or 4 bytes clears the low span bits
        frame4 = (bits_next == 16'd16) && (chan_next == 16'd2);
        frame2 = (bits_next == 16'd16) ^ (chan_next == 16'd2);

        result = '0;
        result.status = st;
        if (st == rwhp_pkg::ST_OK)
        begin
            result.channel_count = chan_next[1:0];
            result.sample_format = (bits_next == 16'd16);
            result.sample_rate   = rate_next;
            result.data_offset   = start_next;
            result.data_length   = {span_next[31:2], span_next[1] & ~frame4,
                                    span_next[0] & ~(frame2 | frame4)};
        end
    end

    // parser state, back to reset after the last word of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            limit_reg  <= '1;
            phase_reg  <= PH_OUTER;
            shift_reg  <= '0;
            tag_reg    <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            fmt_reg    <= '0;
            sub_reg    <= '0;
            chan_reg   <= '0;
            bits_reg   <= '0;
            rate_reg   <= '0;
            found_reg  <= 1'b0;
            start_reg  <= '0;
            span_reg   <= '0;
            err_reg    <= rwhp_pkg::ST_OK;
        end
        else if (step)
        begin
            if (is_last)
            begin
                pos_reg    <= '0;
                limit_reg  <= '1;
                phase_reg  <= PH_OUTER;
                shift_reg  <= '0;
                tag_reg    <= '0;
                length_reg <= '0;
                count_reg  <= '0;
                fmt_reg    <= '0;
                sub_reg    <= '0;
                chan_reg   <= '0;
                bits_reg   <= '0;
                rate_reg   <= '0;
                found_reg  <= 1'b0;
                start_reg  <= '0;
                span_reg   <= '0;
                err_reg    <= rwhp_pkg::ST_OK;
            end
            else
            begin
                pos_reg    <= pos_next;
                limit_reg  <= limit_next;
                phase_reg  <= phase_next;
                shift_reg  <= shift_next;
                tag_reg    <= tag_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                fmt_reg    <= fmt_next;
                sub_reg    <= sub_next;
                chan_reg   <= chan_next;
                bits_reg   <= bits_next;
                rate_reg   <= rate_next;
                found_reg  <= found_next;
                start_reg  <= start_next;
                span_reg   <= span_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

// File: design/riff_wave_header_parser.sv
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   in_byte, is_last
// output    out        out_valid / out_ready status, channel_count, sample_format,
//                                            sample_rate, data_offset, data_length
//
// One file word per cycle unless a last word waits on a full result: a word is first
// registered in the input register, then the chunk walker updates its state and, on the
// last word, the result register loads; out_valid rises with that load.
// rst_n clears the walker to the start of a new file and empties both registers.
// A stalled result holds the input register only when that register holds a last
// word; other words keep flowing while the result waits.
module riff_wave_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [1:0]  channel_count,
    output logic        sample_format,
    output logic [31:0] sample_rate,
    output logic [32:0] data_offset,
    output logic [31:0] data_length
);

    logic                stage_valid_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic                out_valid_reg;
    rwhp_pkg::result_t   result_reg;
    rwhp_pkg::result_t   result_next;
    logic                advance;
    logic                load_result;

    // the staged word moves on unless it is a last word facing a full result not being taken
    assign advance     = stage_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign load_result = advance && last_reg;
    assign in_ready    = !stage_valid_reg || advance;

    rwhp_walker u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (byte_reg),
        .is_last (last_reg),
        .result  (result_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            last_reg <= is_last;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign channel_count = result_reg.channel_count;
    assign sample_format = result_reg.sample_format;
    assign sample_rate   = result_reg.sample_rate;
    assign data_offset   = result_reg.data_offset;
    assign data_length   = result_reg.data_length;

`ifndef NO_ASSERTIONS
    // a failed file carries no format or span
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.status != rwhp_pkg::ST_OK
        |-> result_reg.sample_rate == 32'd0 && result_reg.data_length == 32'd0
            && result_reg.channel_count == 2'd0 && result_reg.data_offset == 33'd0)
        else $error("payload not cleared on error status");

    // a good file reports mono or stereo at a nonzero rate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.status == rwhp_pkg::ST_OK
        |-> (result_reg.channel_count == 2'd1 || result_reg.channel_count == 2'd2)
            && result_reg.sample_rate != 32'd0)
        else $error("bad format on good status");

    // a blocked last word keeps its place in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !advance
        |=> stage_valid_reg && last_reg && $stable(byte_reg))
        else $error("stalled word lost");

    // a result is only overwritten after it has been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && !$past(load_result))
        else $error("result overwritten while stalled");
`endif

endmodule

// File: test/riff_wave_header_parser_chk.sv
`timescale 1ns / 100ps

module riff_wave_header_parser_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  status,
    input  logic [1:0]  channel_count,
    input  logic        sample_format,
    input  logic [31:0] sample_rate,
    input  logic [32:0] data_offset,
    input  logic [31:0] data_length,
    output int          fail_count,
    output int          outstanding
);

    typedef enum logic [1:0] {
        WALK_OUTER,
        WALK_HEADER,
        WALK_BODY,
        WALK_PAD
    } walk_t;

    // chunk walker state
    logic [32:0]       pos_q;
    logic [32:0]       limit_q;
    walk_t             walk_q;
    logic [31:0]       shift_q;
    logic [31:0]       tag_q;
    logic [31:0]       len_q;
    logic [31:0]       cnt_q;
    logic [15:0]       fmt_code_q;
    logic [15:0]       subfmt_q;
    logic [15:0]       chans_q;
    logic [15:0]       bits_q;
    logic [31:0]       rate_q;
    bit                fmt_ok_q;
    logic [32:0]       span_at_q;
    logic [31:0]       span_len_q;
    rwhp_pkg::status_t err_q;

    // header reports still owed by the block, oldest first
    rwhp_pkg::result_t header_reports_q[$];

    function automatic void clear_walker();
        pos_q      = '0;
        limit_q    = '1;
        walk_q     = WALK_OUTER;
        shift_q    = '0;
        tag_q      = '0;
        len_q      = '0;
        cnt_q      = '0;
        fmt_code_q = '0;
        subfmt_q   = '0;
        chans_q    = '0;
        bits_q     = '0;
        rate_q     = '0;
        fmt_ok_q   = 1'b0;
        span_at_q  = '0;
        span_len_q = '0;
        err_q      = rwhp_pkg::ST_OK;
    endfunction

    // only the first error of a file sticks
    function automatic void note_error(input rwhp_pkg::status_t code);
        if (err_q == rwhp_pkg::ST_OK)
            err_q = code;
    endfunction

    // tag and length of a chunk
    function automatic void head_byte(input logic [32:0] at, input logic [7:0] b);
        shift_q = {b, shift_q[31:8]};
        cnt_q++;
        if (cnt_q == 32'd4)
            tag_q = shift_q;
        if (cnt_q < 32'd8)
            return;
        len_q  = shift_q;
        cnt_q  = '0;
        walk_q = WALK_BODY;
        if (tag_q == rwhp_pkg::TAG_FMT && len_q < rwhp_pkg::FMT_BASE_LEN)
        begin
            note_error(rwhp_pkg::ST_FMT_SHORT);
            return;
        end
        if (tag_q == rwhp_pkg::TAG_DATA)
        begin
            span_at_q  = at + 33'd1;
            span_len_q = '0;
        end
        if (len_q == 32'd0)
            walk_q = WALK_HEADER;
    endfunction

    // chunk body, fmt fields captured by offset
    function automatic void body_byte(input logic [7:0] b);
        logic [31:0] k;
        k = cnt_q;
        cnt_q++;
        if (tag_q == rwhp_pkg::TAG_FMT)
        begin
            case (k)
                0:  fmt_code_q = {8'h00, b};
                1:  fmt_code_q = fmt_code_q | {b, 8'h00};
                2:  chans_q    = {8'h00, b};
                3:  chans_q    = chans_q | {b, 8'h00};
                4:  rate_q     = {24'h0, b};
                5:  rate_q     = rate_q | {16'h0, b, 8'h00};
                6:  rate_q     = rate_q | {8'h0, b, 16'h0};
                7:  rate_q     = rate_q | {b, 24'h0};
                14: bits_q     = {8'h00, b};
                15: bits_q     = bits_q | {b, 8'h00};
                24: subfmt_q   = {8'h00, b};
                25: subfmt_q   = subfmt_q | {b, 8'h00};
                default: ;
            endcase
            if (cnt_q == rwhp_pkg::FMT_BASE_LEN)
            begin
                if (fmt_code_q == rwhp_pkg::FMT_PCM)
                    fmt_ok_q = 1'b1;
                else if (fmt_code_q != rwhp_pkg::FMT_EXT)
                begin
                    note_error(rwhp_pkg::ST_FORMAT);
                    return;
                end
                else if (len_q < rwhp_pkg::FMT_EXT_LEN)
                begin
                    note_error(rwhp_pkg::ST_EXT_SHORT);
                    return;
                end
            end
            if (cnt_q == rwhp_pkg::FMT_EXT_LEN && fmt_code_q == rwhp_pkg::FMT_EXT)
            begin
                if (subfmt_q != rwhp_pkg::FMT_PCM)
                begin
                    note_error(rwhp_pkg::ST_EXT_SUBFMT);
                    return;
                end
                fmt_ok_q = 1'b1;
            end
        end
        else if (tag_q == rwhp_pkg::TAG_DATA)
            span_len_q = cnt_q;
        if (cnt_q == len_q)
        begin
            walk_q = len_q[0] ? WALK_PAD : WALK_HEADER;
            cnt_q  = '0;
        end
    endfunction

    // advance by one file word; returns 1 with the report on the last word
    function automatic bit walk_byte(input logic [7:0] b, input logic last,
                                     output rwhp_pkg::result_t rpt);
        logic [32:0]       at;
        logic [31:0]       frame;
        rwhp_pkg::status_t st;
        at  = pos_q;
        rpt = '0;
        if (err_q == rwhp_pkg::ST_OK)
        begin
            if (walk_q == WALK_OUTER)
            begin
                if (at < rwhp_pkg::HEAD_LEN)
                begin
                    shift_q = {b, shift_q[31:8]};
                    if (at == 33'd3 && shift_q != rwhp_pkg::TAG_RIFF)
                        note_error(rwhp_pkg::ST_RIFF_TAG);
                    if (at == 33'd7)
                        limit_q = {1'b0, shift_q} + 33'd8;
                    if (at == 33'd11)
                    begin
                        if (shift_q != rwhp_pkg::TAG_WAVE)
                            note_error(rwhp_pkg::ST_WAVE_TAG);
                        walk_q = WALK_HEADER;
                        cnt_q  = '0;
                    end
                end
            end
            else if (at >= rwhp_pkg::HEAD_LEN && at < limit_q)
            begin
                case (walk_q)
                    WALK_HEADER: head_byte(at, b);
                    WALK_BODY:   body_byte(b);
                    default:
                    begin
                        walk_q = WALK_HEADER;
                        cnt_q  = '0;
                    end
                endcase
            end
        end
        if (pos_q != '1)
            pos_q++;
        if (!last)
            return 1'b0;

        // verdict for the file
        st = rwhp_pkg::ST_OK;
        if (pos_q < rwhp_pkg::HEAD_LEN)
            st = rwhp_pkg::ST_SHORT;
        else
        begin
            // fmt body cut off by the end of the stream
            if (err_q == rwhp_pkg::ST_OK && walk_q == WALK_BODY
                && tag_q == rwhp_pkg::TAG_FMT)
            begin
                if (cnt_q < rwhp_pkg::FMT_BASE_LEN)
                    note_error(rwhp_pkg::ST_FMT_SHORT);
                else if (fmt_code_q == rwhp_pkg::FMT_EXT && cnt_q < rwhp_pkg::FMT_EXT_LEN)
                    note_error(rwhp_pkg::ST_EXT_SHORT);
            end
            if (err_q != rwhp_pkg::ST_OK)
                st = err_q;
            else if (!fmt_ok_q)
                st = rwhp_pkg::ST_NO_FMT;
            else if (chans_q != 16'd1 && chans_q != 16'd2)
                st = rwhp_pkg::ST_CHANNELS;
            else if (bits_q != 16'd8 && bits_q != 16'd16)
                st = rwhp_pkg::ST_BITS;
            else if (rate_q == 32'd0)
                st = rwhp_pkg::ST_RATE_ZERO;
            else if (span_len_q == 32'd0)
                st = rwhp_pkg::ST_NO_DATA;
        end
        rpt.status = st;
        if (st == rwhp_pkg::ST_OK)
        begin
            frame              = {16'h0, bits_q / 16'd8} * {16'h0, chans_q};
            rpt.channel_count  = chans_q[1:0];
            rpt.sample_format  = (bits_q == 16'd16);
            rpt.sample_rate    = rate_q;
            rpt.data_offset    = span_at_q;
            rpt.data_length    = span_len_q & ~(frame - 32'd1);
        end
        clear_walker();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [32:0] want,
                                        input logic [32:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare reports first, then predict from the accepted word
    always @(posedge clk)
    begin
        rwhp_pkg::result_t want;
        if (!rst_n)
        begin
            clear_walker();
            header_reports_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (header_reports_q.size() == 0)
                begin
                    $error("report with none pending, status %0d", status);
                    fail_count++;
                end
                else
                begin
                    want = header_reports_q.pop_front();
                    check_field("status", 33'(want.status), 33'(status));
                    check_field("channel_count", 33'(want.channel_count),
                                33'(channel_count));
                    check_field("sample_format", 33'(want.sample_format),
                                33'(sample_format));
                    check_field("sample_rate", 33'(want.sample_rate), 33'(sample_rate));
                    check_field("data_offset", want.data_offset, data_offset);
                    check_field("data_length", 33'(want.data_length), 33'(data_length));
                end
            end
            if (in_valid && in_ready)
            begin
                if (walk_byte(in_byte, is_last, want))
                    header_reports_q.push_back(want);
            end
        end
        outstanding = header_reports_q.size();
    end

endmodule

// File: test/riff_wave_header_parser_tb.sv
`timescale 1ns / 100ps

module riff_wave_header_parser_tb;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        is_last   = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [3:0]  status;
    logic [1:0]  channel_count;
    logic        sample_format;
    logic [31:0] sample_rate;
    logic [32:0] data_offset;
    logic [31:0] data_length;

    int fail_count;
    int outstanding;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int gap_odds = 0;
    int bytes_sent = 0;
    int files_sent = 0;

    // file image being sent
    logic [7:0] file_q[$];

    riff_wave_header_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .channel_count (channel_count),
        .sample_format (sample_format),
        .sample_rate   (sample_rate),
        .data_offset   (data_offset),
        .data_length   (data_length)
    );

    riff_wave_header_parser_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .channel_count (channel_count),
        .sample_format (sample_format),
        .sample_rate   (sample_rate),
        .data_offset   (data_offset),
        .data_length   (data_length),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // little endian 32-bit field
    function automatic void put32(input logic [31:0] v);
        file_q.push_back(v[7:0]);
        file_q.push_back(v[15:8]);
        file_q.push_back(v[23:16]);
        file_q.push_back(v[31:24]);
    endfunction

    // fmt chunk, mostly sane, sometimes short, odd or with bad fields
    function automatic void add_fmt();
        logic [7:0]  img[40];
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] sub;
        logic [31:0] rate;
        int          len;
        bit          ext;
        ext = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(0, 15);
            1:       len = ext ? $urandom_range(16, 39) : $urandom_range(17, 24);
            2:       len = ext ? $urandom_range(41, 44) : 16;
            default: len = ext ? 40 : 16;
        endcase
        code  = ext ? rwhp_pkg::FMT_EXT : rwhp_pkg::FMT_PCM;
        chans = 16'($urandom_range(1, 2));
        bits  = $urandom_range(0, 1) ? 16'd16 : 16'd8;
        rate  = $urandom;
        sub   = rwhp_pkg::FMT_PCM;
        if ($urandom_range(0, 19) == 0)
            code = 16'($urandom);
        if ($urandom_range(0, 19) == 0)
            chans = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
        if ($urandom_range(0, 19) == 0)
            bits = 16'($urandom);
        case ($urandom_range(0, 19))
            0:       rate = '0;
            1:       rate = '1;
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            sub = 16'($urandom);
        foreach (img[i])
            img[i] = 8'($urandom);
        {img[1], img[0]}                 = code;
        {img[3], img[2]}                 = chans;
        {img[7], img[6], img[5], img[4]} = rate;
        {img[15], img[14]}               = bits;
        {img[25], img[24]}               = sub;
        put32(rwhp_pkg::TAG_FMT);
        put32(32'(len));
        for (int i = 0; i < len; i++)
            file_q.push_back(i < 40 ? img[i] : 8'($urandom));
        if (len % 2)
            file_q.push_back(8'($urandom));
    endfunction

    // data chunk; now and then it claims far more than follows
    function automatic void add_data();
        logic [31:0] claim;
        int          len;
        bit          huge;
        huge  = ($urandom_range(0, 11) == 0);
        len   = $urandom_range(0, 25);
        claim = huge ? ($urandom | 32'h8000_0000) : 32'(len);
        if ($urandom_range(0, 9) == 0)
            len = 0;
        put32(rwhp_pkg::TAG_DATA);
        put32(claim);
        for (int i = 0; i < len; i++)
            file_q.push_back(8'($urandom));
        if (!huge && len % 2)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic void add_other();
        int len;
        len = $urandom_range(0, 9);
        put32($urandom);
        put32(32'(len));
        for (int i = 0; i < len + len % 2; i++)
            file_q.push_back(8'($urandom));
    endfunction

    // a random WAV file, clipped, padded or truncated at times
    function automatic void make_file();
        logic [31:0] riff_len;
        int          chunks;
        int          sel;
        int          size;
        int          keep;
        file_q.delete();
        put32($urandom_range(0, 39) == 0
              ? rwhp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31))
              : rwhp_pkg::TAG_RIFF);
        put32('0);
        put32($urandom_range(0, 39) == 0
              ? rwhp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(0, 31))
              : rwhp_pkg::TAG_WAVE);
        chunks = $urandom_range(0, 4);
        for (int k = 0; k < chunks; k++)
        begin
            sel = $urandom_range(0, 9);
            if ((k == 0 && sel < 8) || sel < 2)
                add_fmt();
            else if ((k == 1 && sel < 8) || sel < 5)
                add_data();
            else
                add_other();
        end
        size = file_q.size();
        case ($urandom_range(0, 9))
            0:       riff_len = $urandom_range(0, size - 8);
            1:       riff_len = '1;
            2:       riff_len = size - 8 + $urandom_range(1, 20);
            default: riff_len = size - 8;
        endcase
        {file_q[7], file_q[6], file_q[5], file_q[4]} = riff_len;
        // trailing bytes past the riff limit
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6))
                file_q.push_back(8'($urandom));
        // cut the stream short
        if ($urandom_range(0, 9) == 0)
        begin
            keep = $urandom_range(1, file_q.size());
            while (file_q.size() > keep)
                void'(file_q.pop_back());
        end
    endfunction

    // one word on the input channel; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_file();
        case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 3;
            default: gap_odds = 15;
        endcase
        if (calm)
            gap_odds = 0;
        foreach (file_q[i])
            send_byte(file_q[i], i == file_q.size() - 1);
        bytes_sent += file_q.size();
        files_sent++;
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300)
                    @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15))
                    @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus and verdict
    initial
    begin
        int round;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one-word file
        file_q = '{8'hFF};
        send_file();
        // all-zero riff tag, all-ones length
        file_q.delete();
        put32('0);
        put32('1);
        put32(rwhp_pkg::TAG_WAVE);
        send_file();
        // bare header with no chunks
        file_q.delete();
        put32(rwhp_pkg::TAG_RIFF);
        put32('1);
        put32(rwhp_pkg::TAG_WAVE);
        send_file();

        round = 0;
        while (bytes_sent < 330 || round < 4)
        begin
            if (round == 1)
            begin
                // flood short files while the receiver holds off
                hold_req = 1'b1;
                repeat (8)
                begin
                    file_q.delete();
                    repeat ($urandom_range(1, 3))
                        file_q.push_back(8'($urandom));
                    send_file();
                end
            end
            if (round == 3)
            begin
                in_valid <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            make_file();
            send_file();
            round++;
        end

        // quiet tail with no idling
        calm = 1'b1;
        repeat (6)
        begin
            make_file();
            send_file();
        end
        in_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("riff_wave_header_parser: match");
        else
            $display("riff_wave_header_parser: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("riff_wave_header_parser: mismatch");
        $finish;
    end

endmodule
